// File: hdl/fmn_pkg.sv
// ----------------------------------------------------------------------------
// FM modulator NCO package
// Shared constants, register codes, status structs and the CORDIC arc table.
// ----------------------------------------------------------------------------
`default_nettype none

package fmn_pkg;

   // default widths of the datapath
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_PHASE_BITS  = 32;
   localparam int DEF_OUT_BITS    = 16;

   // control register file
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CARRIER_STEP   = 2'd0,
      CSR_DEVIATION_STEP = 2'd1,
      CSR_START_PHASE    = 2'd2
   } csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] CARRIER_STEP_RESET   = 32'd0;
   localparam logic [CSR_DATA_BITS-1:0] DEVIATION_STEP_RESET = 32'd42949673;
   localparam logic [CSR_DATA_BITS-1:0] START_PHASE_RESET    = 32'd0;

   // phase queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                   empty;
      logic [QCOUNT_BITS-1:0] count;
   } q_status_type;

   typedef struct packed {
      logic mul_valid;
      logic add_valid;
   } front_status_type;

   // CORDIC: angles at scale 2^30 per quarter turn, vectors at scale 2^30
   localparam int CORDIC_STEPS   = 20;
   localparam int CORDIC_XY_BITS = 34;
   localparam int CORDIC_Z_BITS  = 32;
   localparam int CORDIC_ANGLE   = 32;
   localparam logic signed [CORDIC_XY_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

   function automatic logic signed [CORDIC_Z_BITS-1:0] arc_angle(input int idx);
      logic signed [CORDIC_Z_BITS-1:0] a;
      case (idx)
         0:       a = 32'sd536870912;
         1:       a = 32'sd316933406;
         2:       a = 32'sd167458907;
         3:       a = 32'sd85004756;
         4:       a = 32'sd42667331;
         5:       a = 32'sd21354465;
         6:       a = 32'sd10679838;
         7:       a = 32'sd5340245;
         8:       a = 32'sd2670163;
         9:       a = 32'sd1335087;
         10:      a = 32'sd667544;
         11:      a = 32'sd333772;
         12:      a = 32'sd166886;
         13:      a = 32'sd83443;
         14:      a = 32'sd41722;
         15:      a = 32'sd20861;
         16:      a = 32'sd10430;
         17:      a = 32'sd5215;
         18:      a = 32'sd2608;
         19:      a = 32'sd1304;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// File: hdl/fmn_front.sv
// ----------------------------------------------------------------------------
// FM modulator NCO front end
// Scales each sample by the deviation step and runs the phase accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fmn_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_BITS  = 32
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           in_valid,
   input  wire signed [SAMPLE_BITS-1:0]  in_sample,
   input  wire                           in_first,
   input  wire        [PHASE_BITS-1:0]   deviation_step,
   input  wire        [PHASE_BITS-1:0]   carrier_step,
   input  wire        [PHASE_BITS-1:0]   start_phase,
   output logic                          out_valid,
   output logic       [PHASE_BITS-1:0]   out_phase,
   output fmn_pkg::front_status_type     status
);
   import fmn_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + PHASE_BITS + 1;
   localparam int WIDE_BITS = PROD_BITS + PHASE_BITS;

   // multiply stage
   logic                        mul_valid_ff;
   logic                        mul_first_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PHASE_BITS:0]  dev_signed;

   // scale and add stage
   logic                        add_valid_ff;
   logic                        add_first_ff;
   logic [PHASE_BITS-1:0]       dterm_ff;
   logic [PHASE_BITS-1:0]       dterm_in;
   logic [PHASE_BITS-1:0]       dcar_ff;
   logic [PHASE_BITS-1:0]       dcar_in;
   logic signed [WIDE_BITS-1:0] prod_wide;
   logic signed [WIDE_BITS-1:0] prod_shifted;

   // accumulator
   logic [PHASE_BITS-1:0]       phase_acc_ff;
   logic [PHASE_BITS-1:0]       phase_acc_in;
   logic [PHASE_BITS-1:0]       base_phase;

   assign dev_signed = $signed({1'b0, deviation_step});
   assign prod_in    = in_sample * dev_signed;

   // floor(sample * dev / 2^(SAMPLE_BITS-1)) modulo one turn
   assign prod_wide    = WIDE_BITS'(prod_ff);
   assign prod_shifted = prod_wide >>> (SAMPLE_BITS - 1);
   assign dterm_in     = prod_shifted[PHASE_BITS-1:0];
   assign dcar_in      = dterm_in + carrier_step;

   // restart at the start phase on the first sample of a block
   assign base_phase   = add_first_ff ? start_phase : phase_acc_ff;
   assign out_phase    = base_phase + dterm_ff;
   assign phase_acc_in = base_phase + dcar_ff;
   assign out_valid    = add_valid_ff;

   assign status.mul_valid = mul_valid_ff;
   assign status.add_valid = add_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
         phase_acc_ff <= '0;
      end else begin
         mul_valid_ff <= in_valid;
         add_valid_ff <= mul_valid_ff;
         if (add_valid_ff) begin
            phase_acc_ff <= phase_acc_in;
         end
      end
      if (in_valid) begin
         prod_ff      <= prod_in;
         mul_first_ff <= in_first;
      end
      if (mul_valid_ff) begin
         dterm_ff     <= dterm_in;
         dcar_ff      <= dcar_in;
         add_first_ff <= mul_first_ff;
      end
   end

endmodule

`default_nettype wire

// File: hdl/fmn_queue.sv
// ----------------------------------------------------------------------------
// FM modulator NCO phase queue
// Small FIFO that decouples the phase front end from the CORDIC back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fmn_queue #(
   parameter int WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_en,
   input  wire  [WIDTH-1:0]      wr_data,
   input  wire                   rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output fmn_pkg::q_status_type status
);
   import fmn_pkg::*;

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff;
   logic [QCOUNT_BITS-1:0] count_in;

   localparam logic [QPTR_BITS-1:0]   LAST_PTR = QPTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QCOUNT_BITS-1:0] FULL_CNT = QCOUNT_BITS'(QUEUE_DEPTH);

   assign wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // the top-level credit check holds off requests before the queue can overflow
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < FULL_CNT))
      else $error("phase queue written while full");

   a_no_read_when_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (count_ff != '0))
      else $error("phase queue read while empty");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("phase queue count out of range");

endmodule

`default_nettype wire

// File: hdl/fmn_back.sv
// ----------------------------------------------------------------------------
// FM modulator NCO back end
// Pipelined CORDIC cosine of the phase, rounding, saturation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmn_back #(
   parameter int PHASE_BITS = 32,
   parameter int OUT_BITS   = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire fmn_pkg::q_status_type q_status,
   input  wire         [PHASE_BITS-1:0] q_phase,
   output logic                       q_pop,
   output logic                       empty,
   input  wire                        pop,
   output logic signed [OUT_BITS-1:0] rsp_carrier_out
);
   import fmn_pkg::*;

   localparam int XW    = CORDIC_XY_BITS;
   localparam int ZW    = CORDIC_Z_BITS;
   localparam int N     = CORDIC_STEPS;
   localparam int SHIFT = 31 - OUT_BITS;
   localparam logic signed [XW-1:0] RND_BIAS = XW'(1) <<< (SHIFT - 1);
   localparam logic signed [XW-1:0] POS_LIM  = XW'((1 << (OUT_BITS - 1)) - 1);
   localparam logic signed [XW-1:0] NEG_LIM  = -POS_LIM;

   typedef enum logic [1:0] {
      QUAD_COS     = 2'd0,
      QUAD_NEG_SIN = 2'd1,
      QUAD_NEG_COS = 2'd2,
      QUAD_SIN     = 2'd3
   } quad_type;

   logic                 advance;
   logic [PHASE_BITS+31:0] phase_ext;
   logic [31:0]          angle;

   logic                 valid_ff [N+1];
   logic                 valid_in [N+1];
   logic signed [XW-1:0] x_ff     [N+1];
   logic signed [XW-1:0] x_in     [N+1];
   logic signed [XW-1:0] y_ff     [N+1];
   logic signed [XW-1:0] y_in     [N+1];
   logic signed [ZW-1:0] z_ff     [N+1];
   logic signed [ZW-1:0] z_in     [N+1];
   quad_type             quad_ff  [N+1];
   quad_type             quad_in  [N+1];

   logic signed [XW-1:0] v_sel;
   logic signed [XW-1:0] v_sum;
   logic signed [XW-1:0] v_round;
   logic signed [XW-1:0] v_sat;
   logic                 out_valid_ff;
   logic signed [OUT_BITS-1:0] out_data_ff;

   // hold the whole pipeline while the result register waits
   assign advance = !out_valid_ff || pop;
   assign q_pop   = advance && !q_status.empty;

   // top 32 bits of the phase, left aligned when the phase is narrower
   assign phase_ext = {q_phase, 32'b0};
   assign angle     = phase_ext[PHASE_BITS+31 -: 32];

   assign valid_in[0] = !q_status.empty;
   assign x_in[0]     = CORDIC_GAIN;
   assign y_in[0]     = '0;
   assign z_in[0]     = $signed({2'b00, angle[29:0]});
   assign quad_in[0]  = quad_type'(angle[31:30]);

   for (genvar k = 0; k < N; k++) begin : g_step
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      assign valid_in[k+1] = valid_ff[k];
      assign quad_in[k+1]  = quad_ff[k];
      assign x_in[k+1] = (z_ff[k] >= 0) ? x_ff[k] - dx : x_ff[k] + dx;
      assign y_in[k+1] = (z_ff[k] >= 0) ? y_ff[k] + dy : y_ff[k] - dy;
      assign z_in[k+1] = (z_ff[k] >= 0) ? z_ff[k] - arc_angle(k)
                                        : z_ff[k] + arc_angle(k);
   end

   always_comb begin
      unique case (quad_ff[N])
         QUAD_COS:     v_sel = x_ff[N];
         QUAD_NEG_SIN: v_sel = -y_ff[N];
         QUAD_NEG_COS: v_sel = -x_ff[N];
         QUAD_SIN:     v_sel = y_ff[N];
         default:      v_sel = x_ff[N];
      endcase
      v_sum   = v_sel + RND_BIAS;
      v_round = v_sum >>> SHIFT;
      if (v_round > POS_LIM) begin
         v_sat = POS_LIM;
      end else if (v_round < NEG_LIM) begin
         v_sat = NEG_LIM;
      end else begin
         v_sat = v_round;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) begin
            valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int k = 0; k <= N; k++) begin
            valid_ff[k] <= valid_in[k];
         end
         out_valid_ff <= valid_ff[N];
      end
      if (advance) begin
         for (int k = 0; k <= N; k++) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            quad_ff[k] <= quad_in[k];
         end
         out_data_ff <= v_sat[OUT_BITS-1:0];
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_carrier_out = out_data_ff;

   // a waiting result is never overwritten by the pipeline
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("result register changed while waiting");

   a_pop_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> advance)
      else $error("phase taken from queue while pipeline stalled");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff != {1'b1, {(OUT_BITS-1){1'b0}}}))
      else $error("result outside saturation range");

endmodule

`default_nettype wire

// File: hdl/frequency_modulator_nco_top.sv
// A request accepted on push passes the 2 front stages, the queue, the CORDIC
// stages and the result register before it shows on the rsp ports.
// Throughput: one request per cycle while pop keeps up and full stays low, set by
// the phase accumulator loop and the fully pipelined 20-step CORDIC.
// Reset (synchronous): empties queue and pipeline, clears the phase
// accumulator and loads the control registers with their defaults.
// ----------------------------------------------------------------------------
// FM modulator NCO top level
// Control registers, request credit check, front end, phase queue, CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_modulator_nco_top #(
   parameter int SAMPLE_BITS = fmn_pkg::DEF_SAMPLE_BITS,
   parameter int PHASE_BITS  = fmn_pkg::DEF_PHASE_BITS,
   parameter int OUT_BITS    = fmn_pkg::DEF_OUT_BITS
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     push,
   output logic                                    full,
   input  wire  signed [SAMPLE_BITS-1:0]           req_sample,
   input  wire                                     req_first_of_block,
   output logic                                    empty,
   input  wire                                     pop,
   output logic signed [OUT_BITS-1:0]              rsp_carrier_out,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire         [fmn_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire         [fmn_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import fmn_pkg::*;

   logic [CSR_DATA_BITS-1:0] carrier_step_ff;
   logic [CSR_DATA_BITS-1:0] deviation_step_ff;
   logic [CSR_DATA_BITS-1:0] start_phase_ff;

   logic                     req_accept;
   logic                     front_valid;
   logic [PHASE_BITS-1:0]    front_phase;
   front_status_type         front_status;
   q_status_type             q_status;
   logic [PHASE_BITS-1:0]    q_phase;
   logic                     q_pop;
   logic [QCOUNT_BITS:0]     fill;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_step_ff   <= CARRIER_STEP_RESET;
         deviation_step_ff <= DEVIATION_STEP_RESET;
         start_phase_ff    <= START_PHASE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CARRIER_STEP:   carrier_step_ff   <= csr_data;
            CSR_DEVIATION_STEP: deviation_step_ff <= csr_data;
            CSR_START_PHASE:    start_phase_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // count requests still in the front end against the queue space
   assign fill = {1'b0, q_status.count}
               + (QCOUNT_BITS+1)'(front_status.mul_valid)
               + (QCOUNT_BITS+1)'(front_status.add_valid);
   assign full       = (fill >= (QCOUNT_BITS+1)'(QUEUE_DEPTH));
   assign req_accept = push && !full;

   fmn_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PHASE_BITS  (PHASE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_accept),
      .in_sample      (req_sample),
      .in_first       (req_first_of_block),
      .deviation_step (PHASE_BITS'(deviation_step_ff)),
      .carrier_step   (PHASE_BITS'(carrier_step_ff)),
      .start_phase    (PHASE_BITS'(start_phase_ff)),
      .out_valid      (front_valid),
      .out_phase      (front_phase),
      .status         (front_status)
   );

   fmn_queue #(
      .WIDTH (PHASE_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_phase),
      .rd_en   (q_pop),
      .rd_data (q_phase),
      .status  (q_status)
   );

   fmn_back #(
      .PHASE_BITS (PHASE_BITS),
      .OUT_BITS   (OUT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_phase         (q_phase),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_carrier_out (rsp_carrier_out)
   );

endmodule

`default_nettype wire

// File: sim/tb_frequency_modulator_nco_top.sv
// ----------------------------------------------------------------------------
// FM modulator NCO testbench
// Streams message samples through the modulator under several register
// settings and random push/pop idling, and checks every carrier sample
// against a cycle-free CORDIC phase accumulator model kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_frequency_modulator_nco_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fmn_pkg::*;

   localparam int    ROT_STEPS = 20;
   localparam longint ROT_GAIN = 652032874;
   localparam longint ROT_ARC [ROT_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304
   };

   class carrier_scoreboard;
      logic [31:0] carrier_step;
      logic [31:0] deviation_step;
      logic [31:0] start_phase;
      logic [31:0] phase_acc;
      logic signed [15:0] carrier_q[$];
      int errors;

      function new();
         carrier_step   = CARRIER_STEP_RESET;
         deviation_step = DEVIATION_STEP_RESET;
         start_phase    = START_PHASE_RESET;
         phase_acc      = '0;
         errors         = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_CARRIER_STEP: begin
               carrier_step = val;
            end
            CSR_DEVIATION_STEP: begin
               deviation_step = val;
            end
            CSR_START_PHASE: begin
               start_phase = val;
            end
            default: begin
            end
         endcase
      endfunction

      // floor(s * dev / 2^15), wrapped to one turn
      function logic [31:0] freq_offset(logic signed [15:0] s, logic [31:0] dev);
         longint prod;
         prod = longint'(s) * $signed({32'd0, dev});
         prod = prod >>> 15;
         return prod[31:0];
      endfunction

      function logic signed [15:0] cosine(logic [31:0] ph);
         longint x, y, z, dx, dy, v, r;
         x = ROT_GAIN;
         y = 0;
         z = longint'({34'd0, ph[29:0]});
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - ROT_ARC[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + ROT_ARC[i];
            end
         end
         case (ph[31:30])
            2'd0:    v = x;
            2'd1:    v = -y;
            2'd2:    v = -x;
            default: v = y;
         endcase
         r = (v + 16384) >>> 15;
         if (r > 32767) r = 32767;
         if (r < -32767) r = -32767;
         return r[15:0];
      endfunction

      function void note_request(logic signed [15:0] s, logic first);
         logic [31:0] out_phase;
         if (first) phase_acc = start_phase;
         out_phase = phase_acc + freq_offset(s, deviation_step);
         phase_acc = out_phase + carrier_step;
         carrier_q.push_back(cosine(out_phase));
      endfunction

      function void check_result(logic signed [15:0] got);
         logic signed [15:0] want;
         if (carrier_q.size() == 0) begin
            $display("%0t: unexpected carrier_out %0d with nothing pending", $time, got);
            errors++;
            return;
         end
         want = carrier_q.pop_front();
         if (got !== want) begin
            $display("%0t: carrier_out mismatch, expected %0d, actual %0d",
                     $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [15:0] req_sample = '0;
   logic req_first_of_block = 1'b0;
   logic empty;
   logic pop = 1'b0;
   logic signed [15:0] rsp_carrier_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int send_idle_pct = 21;
   int recv_idle_pct = 71;

   carrier_scoreboard sb;

   frequency_modulator_nco_top dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_sample         (req_sample),
      .req_first_of_block (req_first_of_block),
      .empty              (empty),
      .pop                (pop),
      .rsp_carrier_out    (rsp_carrier_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // result side: random pop stalls
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) sb.check_result(rsp_carrier_out);
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // leaves push high after the request; wait_idle, or an idle draw in the next call, drops it
   task automatic send_item(input logic signed [15:0] s, input logic first);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push               <= 1'b1;
      req_sample         <= s;
      req_first_of_block <= first;
      do @(posedge clock); while (full);
      sb.note_request(s, first);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (sb.carrier_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
   endtask

   task automatic configure(input logic [31:0] carrier, input logic [31:0] dev,
                            input logic [31:0] start);
      write_reg(CSR_CARRIER_STEP, carrier);
      write_reg(CSR_DEVIATION_STEP, dev);
      write_reg(CSR_START_PHASE, start);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed blocks with a restart at the head, plus stray restarts
   task automatic send_random_items(input int count);
      int left_in_block;
      logic signed [15:0] s;
      logic first;
      left_in_block = 0;
      for (int n = 0; n < count; n++) begin
         first = 1'b0;
         if (left_in_block == 0) begin
            first = 1'b1;
            left_in_block = $urandom_range(1, 48);
         end else if ($urandom_range(99) < 4) begin
            first = 1'b1;
         end
         left_in_block--;
         case ($urandom_range(9))
            0:       s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1:       s = 16'(int'($urandom_range(0, 255)) - 128);
            default: s = 16'($urandom);
         endcase
         send_item(s, first);
      end
   endtask

   initial begin
      logic [31:0] c, d, p;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults and cleared phase, no restart
      send_item(16'sd0, 1'b0);
      send_item(16'sd32767, 1'b0);
      wait_idle();

      // quarter-turn carrier walks all four quadrants
      configure(32'h4000_0000, 32'd42949673, 32'h0000_0000);
      send_item(16'sd0, 1'b1);
      send_item(16'sd0, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd32767, 1'b1);
      send_item(-16'sd32768, 1'b0);
      send_item(-16'sd1, 1'b1);
      send_item(16'sd1, 1'b1);
      send_item(16'sd16384, 1'b0);
      send_item(-16'sd16384, 1'b0);
      wait_idle();

      // carrier above half a turn, zero deviation
      configure(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(16'sd32767, 1'b1);
      send_item(-16'sd32768, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd12345, 1'b1);
      wait_idle();

      // largest deviation at full-scale samples
      configure(32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000);
      send_item(16'sd32767, 1'b1);
      send_item(-16'sd32768, 1'b0);
      send_item(-16'sd1, 1'b0);
      send_item(16'sd1, 1'b0);
      send_item(16'sd0, 1'b1);
      send_item(-16'sd32768, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: begin
               c = $urandom_range(0, 32'h8000_0000);
               d = $urandom;
               p = $urandom;
            end
            1: begin
               c = 32'h0000_0000;
               d = 32'h0000_0001;
               p = 32'h0000_0000;
            end
            2: begin
               c = 32'h8000_0000;
               d = 32'hFFFF_FFFF;
               p = 32'hFFFF_FFFF;
            end
            3: begin
               c = $urandom_range(0, 32'h8000_0000);
               d = $urandom_range(1, 32'h0100_0000);
               p = $urandom;
            end
            default: begin
               c = $urandom;
               d = $urandom;
               p = $urandom;
            end
         endcase
         configure(c, d, p);
         send_random_items(313);
         wait_idle();
      end

      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
hdl/fmn_pkg.sv
hdl/fmn_front.sv
hdl/fmn_queue.sv
hdl/fmn_back.sv
hdl/frequency_modulator_nco_top.sv
sim/tb_frequency_modulator_nco_top.sv
